// ===== src/tcb_pkg.sv =====
`default_nettype none

package tcb_pkg;

  // Default screen geometry.
  localparam int ROWS_DEF    = 25;
  localparam int COLUMNS_DEF = 80;

  // Fixed field widths of the item and result beats.
  localparam int CHAR_W     = 8;
  localparam int ROW_PORT_W = 5;
  localparam int COL_PORT_W = 7;
  localparam int STATUS_W   = 3;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Action codes.
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result status codes.
  localparam status_t ST_STORED   = 3'd0;
  localparam status_t ST_NEWLINE  = 3'd1;
  localparam status_t ST_SCROLLED = 3'd2;
  localparam status_t ST_DROPPED  = 3'd3;
  localparam status_t ST_READ     = 3'd4;

  // Special characters.
  localparam char_t CHAR_NEWLINE = 8'd10;
  localparam char_t CHAR_NUL     = 8'd0;

endpackage

`default_nettype wire

// ===== src/tcb_store.sv =====
`default_nettype none

// Character memory with a built-in row clearing engine. After reset the engine
// sweeps every row; on request it sweeps one row. While it runs it owns the
// write port.
module tcb_store #(
  parameter int ROWS    = tcb_pkg::ROWS_DEF,
  parameter int COLUMNS = tcb_pkg::COLUMNS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          clr_start,
  input  wire  [$clog2(ROWS)-1:0]      clr_row,
  output logic                         clr_busy,
  input  wire                          wr_en,
  input  wire  [$clog2(ROWS)+$clog2(COLUMNS+1)-1:0] wr_addr,
  input  wire  tcb_pkg::char_t         wr_data,
  input  wire                          rd_en,
  input  wire  [$clog2(ROWS)+$clog2(COLUMNS+1)-1:0] rd_addr,
  output tcb_pkg::char_t               rd_data
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int DEPTH = ROWS << CW;

  tcb_pkg::char_t mem [DEPTH];

  logic          busy;
  logic          all_rows;
  logic [RW-1:0] sweep_row;
  logic [CW-1:0] sweep_col;

  assign clr_busy = busy;

  // Sweep sequencer: one cell per cycle, columns 0 to COLUMNS of a row.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      all_rows  <= 1'b1;
      sweep_row <= '0;
      sweep_col <= '0;
    end else if (busy) begin
      if (sweep_col == CW'(COLUMNS)) begin
        sweep_col <= '0;
        if (all_rows && sweep_row != RW'(ROWS - 1)) begin
          sweep_row <= sweep_row + 1'b1;
        end else begin
          busy <= 1'b0;
        end
      end else begin
        sweep_col <= sweep_col + 1'b1;
      end
    end else if (clr_start) begin
      busy      <= 1'b1;
      all_rows  <= 1'b0;
      sweep_row <= clr_row;
      sweep_col <= '0;
    end
  end

  // Single write port shared by the sweep and character stores.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[{sweep_row, sweep_col}] <= tcb_pkg::CHAR_NUL;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/text_console_buffer.sv =====
`default_nettype none

// Channel | Handshake          | Payload
// --------+--------------------+------------------------------------------
// in      | in_valid/in_stall  | action, char_in, read_row, read_col
// out     | out_valid/out_stall| status, cell_row, cell_col, char_out
//
// A put beat passes from acceptance through the holding register into the
// output register; a read beat first passes through the registered read port
// of the memory. No beat is accepted while a result is held or a read runs.
// A scrolling newline clears one row of the memory, all COLUMNS+1 cells,
// during which no beat is accepted.
// After reset every row of the memory, columns 0 to COLUMNS, is cleared
// before the first beat is accepted.
// A result waits in a holding register while the output stage is stalled.
module text_console_buffer #(
  parameter int ROWS    = tcb_pkg::ROWS_DEF,
  parameter int COLUMNS = tcb_pkg::COLUMNS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   action,
  input  wire  [tcb_pkg::CHAR_W-1:0]            char_in,
  input  wire  [tcb_pkg::ROW_PORT_W-1:0]        read_row,
  input  wire  [tcb_pkg::COL_PORT_W-1:0]        read_col,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [tcb_pkg::STATUS_W-1:0]          status,
  output logic [tcb_pkg::ROW_PORT_W-1:0]        cell_row,
  output logic [tcb_pkg::COL_PORT_W-1:0]        cell_col,
  output logic [tcb_pkg::CHAR_W-1:0]            char_out
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS + 1);
  localparam int AW = RW + CW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic                         state;
  logic [RW-1:0]                cursor_row;
  logic [CW-1:0]                cursor_col;
  logic [RW-1:0]                top_base;
  logic [RW-1:0]                top_base_next;

  logic                         pend;
  tcb_pkg::status_t             res_status;
  logic [tcb_pkg::ROW_PORT_W-1:0] res_row;
  logic [tcb_pkg::COL_PORT_W-1:0] res_col;
  tcb_pkg::char_t               res_char;

  tcb_pkg::status_t             new_status;
  logic [tcb_pkg::ROW_PORT_W-1:0] new_row;
  logic [tcb_pkg::COL_PORT_W-1:0] new_col;
  tcb_pkg::char_t               new_char;
  logic                         res_set;

  logic [tcb_pkg::ROW_PORT_W-1:0] rd_row_q;
  logic [tcb_pkg::COL_PORT_W-1:0] rd_col_q;
  logic                         rd_ok;

  logic                         acc;
  logic                         is_put;
  logic                         is_newline;
  logic                         last_row;
  logic                         store_ok;
  logic                         read_in_range;
  logic [RW-1:0]                cursor_phys;
  logic [RW-1:0]                read_phys;
  logic                         out_free;

  logic                         clr_start;
  logic                         clr_busy;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  tcb_pkg::char_t               rd_data;

  // Map a logical row to its physical row in the ring of rows.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                             input logic [RW-1:0] logical);
    logic [RW:0] sum;
    sum = {1'b0, base} + {1'b0, logical};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  // Handshake and decode of the incoming beat.
  assign in_stall      = rst || pend || (state != ST_IDLE) || clr_busy;
  assign acc           = in_valid && !in_stall;
  assign out_free      = !out_valid || !out_stall;
  assign is_put        = (action == tcb_pkg::ACT_PUT);
  assign is_newline    = (char_in == tcb_pkg::CHAR_NEWLINE);
  assign last_row      = (cursor_row == RW'(ROWS - 1));
  assign store_ok      = (char_in != tcb_pkg::CHAR_NUL) &&
                         (32'(cursor_col) < 32'(COLUMNS - 1));
  assign read_in_range = (32'(read_row) < 32'(ROWS)) &&
                         (32'(read_col) <= 32'(COLUMNS));
  assign cursor_phys   = phys_row(top_base, cursor_row);
  assign read_phys     = phys_row(top_base, RW'(read_row));
  assign top_base_next = (top_base == RW'(ROWS - 1)) ? '0 : top_base + 1'b1;

  // Memory requests.
  assign wr_en     = acc && is_put && !is_newline && store_ok;
  assign wr_addr   = {cursor_phys, cursor_col};
  assign rd_en     = acc && !is_put && read_in_range;
  assign rd_addr   = {read_phys, CW'(read_col)};
  assign clr_start = acc && is_put && is_newline && last_row;

  tcb_store #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .clr_start (clr_start),
    .clr_row   (top_base),
    .clr_busy  (clr_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (char_in),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Result of the current beat: a finished read, or a put decided at once.
  assign res_set = (acc && is_put) || (state == ST_RD);

  always_comb begin
    new_status = tcb_pkg::ST_DROPPED;
    new_row    = tcb_pkg::ROW_PORT_W'(cursor_row);
    new_col    = tcb_pkg::COL_PORT_W'(cursor_col);
    new_char   = tcb_pkg::CHAR_NUL;
    if (state == ST_RD) begin
      new_status = tcb_pkg::ST_READ;
      new_row    = rd_row_q;
      new_col    = rd_col_q;
      new_char   = rd_ok ? rd_data : tcb_pkg::CHAR_NUL;
    end else if (is_newline) begin
      new_col = '0;
      if (last_row) begin
        new_status = tcb_pkg::ST_SCROLLED;
      end else begin
        new_status = tcb_pkg::ST_NEWLINE;
        new_row    = tcb_pkg::ROW_PORT_W'(RW'(cursor_row + 1'b1));
      end
    end else if (store_ok) begin
      new_status = tcb_pkg::ST_STORED;
      new_char   = char_in;
    end
  end

  // Control state: sequencer, cursor, ring base and the two result stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
      cursor_row <= '0;
      cursor_col <= '0;
      top_base   <= '0;
    end else begin
      if (out_free) begin
        out_valid <= pend;
        if (pend) begin
          pend <= 1'b0;
        end
      end
      if (res_set) begin
        pend <= 1'b1;
      end
      if (state == ST_RD) begin
        state <= ST_IDLE;
      end else if (acc && !is_put) begin
        state <= ST_RD;
      end
      if (acc && is_put) begin
        if (is_newline) begin
          cursor_col <= '0;
          if (last_row) begin
            top_base <= top_base_next;
          end else begin
            cursor_row <= cursor_row + 1'b1;
          end
        end else if (store_ok) begin
          cursor_col <= cursor_col + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc && !is_put) begin
      rd_row_q <= read_row;
      rd_col_q <= read_col;
      rd_ok    <= read_in_range;
    end
    if (res_set) begin
      res_status <= new_status;
      res_row    <= new_row;
      res_col    <= new_col;
      res_char   <= new_char;
    end
    if (out_free && pend) begin
      status   <= res_status;
      cell_row <= res_row;
      cell_col <= res_col;
      char_out <= res_char;
    end
  end

  // The clearing sweep and a character store never share the write port.
  assert property (@(posedge clk) disable iff (rst) !(wr_en && clr_busy))
    else $error("character store during a clearing sweep");

  // A finished read always leaves a result in the holding register.
  assert property (@(posedge clk) disable iff (rst) (state == ST_RD) |=> pend)
    else $error("read result lost");

  // The cursor column never exceeds COLUMNS-1, one past the last storable column.
  assert property (@(posedge clk) disable iff (rst)
    32'(cursor_col) <= 32'(COLUMNS - 1))
    else $error("cursor column out of range");

  // Every accepted beat blocks the input for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst) acc |=> in_stall)
    else $error("beat accepted while the previous one is still in work");

endmodule

`default_nettype wire
